// ----- design/haversine_bearing_distance_top_defines.svh -----
// Assertion macros shared by the haversine bearing and distance design.
// Include this header from any file that declares concurrent checks.
`ifndef HAVERSINE_BEARING_DISTANCE_TOP_DEFINES_SVH
`define HAVERSINE_BEARING_DISTANCE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property checked on every clock edge outside reset.
`define HBD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hbd assertion failed");
// Same-cycle implication checked outside reset.
`define HBD_IMPLY(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hbd implication failed");
`else
`define HBD_ASSERT(lbl, clk, rst_n, prop)
`define HBD_IMPLY(lbl, clk, rst_n, pre, post)
`endif

`endif

// ----- design/hbd_pkg.sv -----
// Shared types, constants and tables for the haversine bearing and distance block.
// No dependencies; the cell modules and the top module import this package.
package hbd_pkg;

  // Data path widths.
  localparam int ROT_W    = 34;  // rotation CORDIC x, y and angle
  localparam int VEC_XY_W = 36;  // vectoring CORDIC x and y
  localparam int VEC_Z_W  = 35;  // vectoring CORDIC angle accumulator
  localparam int Q_W      = 34;  // signed Q30 products
  localparam int SQ_W     = 61;  // square root radicand and partial root
  localparam int SQRT_STEPS = 31;
  localparam int DV_W     = 31;  // offset degree value fed to the phase converter
  localparam int ATAN_ENTRIES = 40;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_TIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOSE = 2'd1;
  localparam logic [CFG_DATA_W-1:0] TIGHT_RESET = 24'd327680;
  localparam logic [CFG_DATA_W-1:0] LOOSE_RESET = 24'd983040;

  // Verdict codes.
  localparam logic [1:0] VERDICT_TIGHT  = 2'd0;
  localparam logic [1:0] VERDICT_LOOSE  = 2'd1;
  localparam logic [1:0] VERDICT_BEYOND = 2'd2;

  // Arithmetic constants.
  localparam logic [ROT_W-1:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [Q_W-1:0]   ONE_Q30     = 34'd1073741824;
  localparam logic [24:0]      FULL_CIRCLE = 25'd23592960;
  localparam logic [23:0]      HALF_CIRCLE = 24'd11796480;
  localparam logic [31:0]      MILE_MUL    = 32'd3260268412;
  localparam logic [32:0]      KM_MUL      = 33'd5246880366;
  // Degrees are biased by 45 * 2^24 so the divide by 45 sees a positive value;
  // the bias adds 2^33 to the phase, which vanishes modulo one turn.
  localparam logic [DV_W-1:0]  DEG_OFFSET  = 31'd754974720;
  localparam logic [31:0]      DIV45_MUL   = 32'd3054198967;  // ceil(2^37 / 45)

  typedef struct packed {
    logic [ROT_W-1:0] x;
    logic [ROT_W-1:0] y;
    logic [ROT_W-1:0] z;
    logic             neg;
  } rot_t;

  typedef struct packed {
    logic [VEC_XY_W-1:0] x;
    logic [VEC_XY_W-1:0] y;
    logic [VEC_Z_W-1:0]  z;
    logic                zero;
  } vec_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] r;
  } sqrt_t;

  typedef struct packed {
    logic [24:0] head;
    logic        present;
  } side_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] v;
    unique case (i)
      0: v = 32'd536870912;   1: v = 32'd316933406;   2: v = 32'd167458907;
      3: v = 32'd85004756;    4: v = 32'd42667331;    5: v = 32'd21354465;
      6: v = 32'd10679838;    7: v = 32'd5340245;     8: v = 32'd2670163;
      9: v = 32'd1335087;     10: v = 32'd667544;     11: v = 32'd333772;
      12: v = 32'd166886;     13: v = 32'd83443;      14: v = 32'd41722;
      15: v = 32'd20861;      16: v = 32'd10430;      17: v = 32'd5215;
      18: v = 32'd2608;       19: v = 32'd1304;       20: v = 32'd652;
      21: v = 32'd326;        22: v = 32'd163;        23: v = 32'd81;
      24: v = 32'd41;         25: v = 32'd20;         26: v = 32'd10;
      27: v = 32'd5;          28: v = 32'd3;          29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Phase contribution of the remainder r (0..44) of a degree value divided by 45,
  // floor((r * 4096 + 180) / 360), held as a constant table.
  function automatic logic [8:0] phase_frac(input logic [5:0] r);
    logic [8:0] v;
    unique case (r)
      6'd0:  v = 9'd0;    6'd1:  v = 9'd11;   6'd2:  v = 9'd23;   6'd3:  v = 9'd34;
      6'd4:  v = 9'd46;   6'd5:  v = 9'd57;   6'd6:  v = 9'd68;   6'd7:  v = 9'd80;
      6'd8:  v = 9'd91;   6'd9:  v = 9'd102;  6'd10: v = 9'd114;  6'd11: v = 9'd125;
      6'd12: v = 9'd137;  6'd13: v = 9'd148;  6'd14: v = 9'd159;  6'd15: v = 9'd171;
      6'd16: v = 9'd182;  6'd17: v = 9'd193;  6'd18: v = 9'd205;  6'd19: v = 9'd216;
      6'd20: v = 9'd228;  6'd21: v = 9'd239;  6'd22: v = 9'd250;  6'd23: v = 9'd262;
      6'd24: v = 9'd273;  6'd25: v = 9'd284;  6'd26: v = 9'd296;  6'd27: v = 9'd307;
      6'd28: v = 9'd319;  6'd29: v = 9'd330;  6'd30: v = 9'd341;  6'd31: v = 9'd353;
      6'd32: v = 9'd364;  6'd33: v = 9'd375;  6'd34: v = 9'd387;  6'd35: v = 9'd398;
      6'd36: v = 9'd410;  6'd37: v = 9'd421;  6'd38: v = 9'd432;  6'd39: v = 9'd444;
      6'd40: v = 9'd455;  6'd41: v = 9'd466;  6'd42: v = 9'd478;  6'd43: v = 9'd489;
      6'd44: v = 9'd501;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/hbd_stream_if.sv -----
// Valid/ready channel interfaces for the input and result beats.
// Field widths follow the block's item formats; no package dependency.
interface hbd_in_if;
  logic               valid;
  logic               ready;
  logic signed [27:0] lat_from;
  logic signed [28:0] lon_from;
  logic signed [27:0] lat_to;
  logic signed [28:0] lon_to;
  logic        [24:0] measured_heading;
  logic               heading_present;

  modport source (output valid, lat_from, lon_from, lat_to, lon_to,
                  measured_heading, heading_present, input ready);
  modport sink   (input valid, lat_from, lon_from, lat_to, lon_to,
                  measured_heading, heading_present, output ready);
endinterface

interface hbd_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] true_bearing;
  logic [21:0] distance_miles;
  logic [22:0] distance_km;
  logic [23:0] heading_error;
  logic [1:0]  verdict;
  logic        verdict_valid;

  modport source (output valid, true_bearing, distance_miles, distance_km,
                  heading_error, verdict, verdict_valid, input ready);
  modport sink   (input valid, true_bearing, distance_miles, distance_km,
                  heading_error, verdict, verdict_valid, output ready);
endinterface

// ----- design/hbd_phase_cell.sv -----
// Two-stage converter from biased degrees (2^-20 units) to a 2^-32 turn phase.
// Depends on hbd_pkg for widths, the reciprocal of 45 and the remainder table.
module hbd_phase_cell (
  input  logic                     clk,
  input  logic                     en,
  input  logic [hbd_pkg::DV_W-1:0] dv,
  output logic [31:0]              phase_r
);
  import hbd_pkg::*;

  logic [62:0]     prod;
  logic [25:0]     q_r, q_nxt;
  logic [DV_W-1:0] dv_r;
  logic [DV_W-1:0] rem;
  logic [34:0]     sum;
  logic [31:0]     phase_nxt;

  // Quotient by 45 through the reciprocal product.
  always_comb begin
    prod  = 63'(dv) * 63'(DIV45_MUL);
    q_nxt = prod[62:37];
  end

  // Remainder picks the fraction; each unit of quotient is 512 phase steps.
  always_comb begin
    rem       = dv_r - DV_W'(q_r * 26'd45);
    sum       = {q_r, 9'b0} + 35'(phase_frac(rem[5:0]));
    phase_nxt = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r     <= q_nxt;
      dv_r    <= dv;
      phase_r <= phase_nxt;
    end
  end
endmodule

// ----- design/hbd_rot_cell.sv -----
// One rotation-mode CORDIC step for sine and cosine, registered.
// Depends on hbd_pkg for the rotation type and the arctangent table.
module hbd_rot_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  hbd_pkg::rot_t a,
  output hbd_pkg::rot_t q_r
);
  import hbd_pkg::*;

  localparam logic [ROT_W-1:0] ATAN_K = ROT_W'(atan_entry(STEP));

  logic signed [ROT_W-1:0] xs, ys;
  rot_t q_nxt;

  // Rotate toward zero residual angle.
  always_comb begin
    xs = $signed(a.x) >>> STEP;
    ys = $signed(a.y) >>> STEP;
    q_nxt = a;
    if (!a.z[ROT_W-1]) begin
      q_nxt.x = a.x - ys;
      q_nxt.y = a.y + xs;
      q_nxt.z = a.z - ATAN_K;
    end else begin
      q_nxt.x = a.x + ys;
      q_nxt.y = a.y - xs;
      q_nxt.z = a.z + ATAN_K;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end
endmodule

// ----- design/hbd_sqrt_cell.sv -----
// One digit of a restoring integer square root, registered.
// Depends on hbd_pkg for the radicand and root widths.
module hbd_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           en,
  input  hbd_pkg::sqrt_t a,
  output hbd_pkg::sqrt_t q_r
);
  import hbd_pkg::*;

  localparam logic [SQ_W-1:0] BIT_K = SQ_W'(1) << (SQ_W - 1 - 2 * STEP);

  logic [SQ_W-1:0] trial;
  sqrt_t q_nxt;

  // Keep the digit when the trial subtraction does not go negative.
  always_comb begin
    trial = a.r + BIT_K;
    if (a.n >= trial) begin
      q_nxt.n = a.n - trial;
      q_nxt.r = (a.r >> 1) + BIT_K;
    end else begin
      q_nxt.n = a.n;
      q_nxt.r = a.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end
endmodule

// ----- design/hbd_vec_cell.sv -----
// One vectoring-mode CORDIC step for atan2, registered.
// Depends on hbd_pkg for the vectoring type and the arctangent table.
module hbd_vec_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  hbd_pkg::vec_t a,
  output hbd_pkg::vec_t q_r
);
  import hbd_pkg::*;

  localparam logic [VEC_Z_W-1:0] ATAN_K = VEC_Z_W'(atan_entry(STEP));

  logic signed [VEC_XY_W-1:0] xs, ys;
  logic y_pos;
  vec_t q_nxt;

  // Drive y toward zero and accumulate the angle turned.
  always_comb begin
    xs = $signed(a.x) >>> STEP;
    ys = $signed(a.y) >>> STEP;
    y_pos = !a.y[VEC_XY_W-1] && (a.y != '0);
    q_nxt = a;
    if (y_pos) begin
      q_nxt.x = a.x + ys;
      q_nxt.y = a.y - xs;
      q_nxt.z = a.z + ATAN_K;
    end else begin
      q_nxt.x = a.x - ys;
      q_nxt.y = a.y + xs;
      q_nxt.z = a.z - ATAN_K;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end
endmodule

// ----- design/haversine_bearing_distance_top.sv -----
// Haversine distance and initial bearing engine, fully pipelined.
// The input channel takes one beat per cycle: two points in 2^-20 degree
// units and an optional measured heading. Each input beat yields exactly one
// result beat with the bearing (2^-16 deg), distance in miles and km (2^-8)
// and, with a heading, the wrapped error and a three-level verdict.
// Throughput is one beat per cycle; it is set by the chains of rotation,
// square-root and vectoring cells that each hold one item per stage.
// The whole pipeline advances together: when the result register holds a
// beat that the receiver does not take, every stage holds and in ready is low.
// Thresholds are written through the cfg port and apply to later results.
// Reset (synchronous, active low) empties the pipeline and restores the
// thresholds to five and fifteen degrees.
// Depends on hbd_pkg, hbd_stream_if, the cell modules and the defines header.
`include "haversine_bearing_distance_top_defines.svh"

module haversine_bearing_distance_top #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hbd_in_if.sink                         in_ch,
  hbd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [hbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hbd_pkg::*;

  localparam int N      = CORDIC_ITERATIONS;
  localparam int L      = 2 * N + 43;   // total stages, last is the result register
  localparam int SD_LEN = 2 * N + 39;   // heading side line up to the vectoring end

  typedef struct packed {
    logic [Q_W-1:0] hp, hl, m1, yb, t1, m2, cdl;
  } p1_t;
  typedef struct packed {
    logic [Q_W-1:0] hp, pa, p3, yb, t1;
  } p2_t;
  typedef struct packed {
    logic [Q_W-1:0] yb, xb;
  } bx_t;
  typedef struct packed {
    logic [30:0] h;
    logic [24:0] bearing;
    logic [24:0] head;
    logic        present;
  } e1_t;
  typedef struct packed {
    logic [63:0] pm, pk;
    logic [24:0] bearing;
    logic [24:0] diff;
    logic        present;
  } e2_t;
  typedef struct packed {
    logic [21:0] mi;
    logic [22:0] km;
    logic [24:0] bearing;
    logic [23:0] diff;
    logic        present;
  } e3_t;
  typedef struct packed {
    logic [24:0] bearing;
    logic [21:0] mi;
    logic [22:0] km;
    logic [23:0] herr;
    logic [1:0]  verdict;
    logic        vvalid;
  } out_t;

  logic adv;
  logic [L-1:0] vld_r, vld_nxt;
  logic [CFG_DATA_W-1:0] tight_r, tight_nxt, loose_r, loose_nxt;

  // Global advance: the result register is empty or its beat is taken.
  assign adv         = !vld_r[L-1] || out_ch.ready;
  assign in_ch.ready = adv;

  // Valid bits travel with the items.
  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = {vld_r[L-2:0], in_ch.valid};
    end
  end

  // Threshold registers.
  always_comb begin
    tight_nxt = tight_r;
    loose_nxt = loose_r;
    if (cfg_we) begin
      if (cfg_idx == CFG_TIGHT) begin
        tight_nxt = cfg_wdata;
      end
      if (cfg_idx == CFG_LOOSE) begin
        loose_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      tight_r <= TIGHT_RESET;
      loose_r <= LOOSE_RESET;
    end else begin
      vld_r   <= vld_nxt;
      tight_r <= tight_nxt;
      loose_r <= loose_nxt;
    end
  end

  // Stage 0: angle differences and the bias for the phase converters.
  logic [28:0] dlat;
  logic [29:0] dlon;
  logic [DV_W-1:0] dv_nxt [4];
  logic [DV_W-1:0] dv_r [4];
  side_t sd_r [SD_LEN];

  always_comb begin
    dlat = {in_ch.lat_to[27], in_ch.lat_to} - {in_ch.lat_from[27], in_ch.lat_from};
    dlon = {in_ch.lon_to[28], in_ch.lon_to} - {in_ch.lon_from[28], in_ch.lon_from};
    dv_nxt[0] = {{3{in_ch.lat_from[27]}}, in_ch.lat_from} + DEG_OFFSET;
    dv_nxt[1] = {{3{in_ch.lat_to[27]}}, in_ch.lat_to} + DEG_OFFSET;
    dv_nxt[2] = {{2{dlat[28]}}, dlat} + DEG_OFFSET;
    dv_nxt[3] = {dlon[29], dlon} + DEG_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        dv_r[c] <= dv_nxt[c];
      end
      sd_r[0] <= '{head: in_ch.measured_heading, present: in_ch.heading_present};
      for (int k = 1; k < SD_LEN; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  // Stages 1 and 2: degree to phase for lat1, lat2, dlat and dlon.
  logic [31:0] ph [4];
  for (genvar c = 0; c < 4; c++) begin : g_phase
    hbd_phase_cell u_phase (.clk(clk), .en(adv), .dv(dv_r[c]), .phase_r(ph[c]));
  end

  // Stage 3: fold the phase into the right half plane and start the rotation.
  rot_t rot_init_r [4];
  rot_t rot_q [4][N];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        logic [31:0] t, z32;
        t   = ph[c] + 32'h4000_0000;
        z32 = t[31] ? (ph[c] + 32'h8000_0000) : ph[c];
        rot_init_r[c].x   <= CORDIC_GAIN;
        rot_init_r[c].y   <= '0;
        rot_init_r[c].z   <= {{(ROT_W-32){z32[31]}}, z32};
        rot_init_r[c].neg <= t[31];
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_rot
    for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_first
        hbd_rot_cell #(.STEP(i)) u_cell (
          .clk(clk), .en(adv), .a(rot_init_r[c]), .q_r(rot_q[c][i]));
      end else begin : g_next
        hbd_rot_cell #(.STEP(i)) u_cell (
          .clk(clk), .en(adv), .a(rot_q[c][i-1]), .q_r(rot_q[c][i]));
      end
    end
  end

  // Signed Q30 product, floored after the shift.
  function automatic logic [Q_W-1:0] mulq(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
    logic signed [2*Q_W-1:0] p;
    p = $signed(a) * $signed(b);
    return Q_W'(p >>> 30);
  endfunction

  // P1: undo the fold, haversine halves and first products.
  logic [Q_W-1:0] sn [4];
  logic [Q_W-1:0] cs [4];
  p1_t p1_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sn[c] = rot_q[c][N-1].neg ? -rot_q[c][N-1].y : rot_q[c][N-1].y;
      cs[c] = rot_q[c][N-1].neg ? -rot_q[c][N-1].x : rot_q[c][N-1].x;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r.hp  <= Q_W'($signed(ONE_Q30 - cs[2]) >>> 1);
      p1_r.hl  <= Q_W'($signed(ONE_Q30 - cs[3]) >>> 1);
      p1_r.m1  <= mulq(cs[0], cs[1]);
      p1_r.yb  <= mulq(sn[3], cs[1]);
      p1_r.t1  <= mulq(cs[0], sn[1]);
      p1_r.m2  <= mulq(sn[0], cs[1]);
      p1_r.cdl <= cs[3];
    end
  end

  // P2: second-level products.
  p2_t p2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r.hp <= p1_r.hp;
      p2_r.pa <= mulq(p1_r.m1, p1_r.hl);
      p2_r.p3 <= mulq(p1_r.m2, p1_r.cdl);
      p2_r.yb <= p1_r.yb;
      p2_r.t1 <= p1_r.t1;
    end
  end

  // P3: clamp the haversine term and finish the bearing vector.
  logic [Q_W-1:0] asum;
  logic [30:0] a_nxt, a_r, b_r;
  bx_t bx_r [SQRT_STEPS+1];

  always_comb begin
    asum = p2_r.hp + p2_r.pa;
    if (asum[Q_W-1]) begin
      a_nxt = '0;
    end else if (asum > ONE_Q30) begin
      a_nxt = 31'(ONE_Q30);
    end else begin
      a_nxt = asum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= a_nxt;
      b_r <= 31'(ONE_Q30) - a_nxt;
      bx_r[0] <= '{yb: p2_r.yb, xb: p2_r.t1 - p2_r.p3};
      for (int k = 1; k <= SQRT_STEPS; k++) begin
        bx_r[k] <= bx_r[k-1];
      end
    end
  end

  // Square roots of a and 1 - a, both scaled by 2^30.
  sqrt_t sq_in [2];
  sqrt_t sq_q [2][SQRT_STEPS];

  assign sq_in[0] = '{n: {a_r, 30'b0}, r: '0};
  assign sq_in[1] = '{n: {b_r, 30'b0}, r: '0};

  for (genvar v = 0; v < 2; v++) begin : g_sqrt
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
      if (k == 0) begin : g_first
        hbd_sqrt_cell #(.STEP(k)) u_cell (
          .clk(clk), .en(adv), .a(sq_in[v]), .q_r(sq_q[v][k]));
      end else begin : g_next
        hbd_sqrt_cell #(.STEP(k)) u_cell (
          .clk(clk), .en(adv), .a(sq_q[v][k-1]), .q_r(sq_q[v][k]));
      end
    end
  end

  // Start of vectoring: mirror a left half plane vector, note the zero vector.
  function automatic vec_t vec_start(input logic [VEC_XY_W-1:0] y,
                                     input logic [VEC_XY_W-1:0] x);
    vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x[VEC_XY_W-1]) begin
      v.x = -x;
      v.y = -y;
      v.z = VEC_Z_W'(33'h0_8000_0000);
    end else begin
      v.x = x;
      v.y = y;
      v.z = '0;
    end
    return v;
  endfunction

  vec_t vec_init_r [2];
  vec_t vec_q [2][N];

  always_ff @(posedge clk) begin
    if (adv) begin
      vec_init_r[0] <= vec_start(VEC_XY_W'(sq_q[0][SQRT_STEPS-1].r[30:0]),
                                 VEC_XY_W'(sq_q[1][SQRT_STEPS-1].r[30:0]));
      vec_init_r[1] <= vec_start(
        {{(VEC_XY_W-Q_W){bx_r[SQRT_STEPS].yb[Q_W-1]}}, bx_r[SQRT_STEPS].yb},
        {{(VEC_XY_W-Q_W){bx_r[SQRT_STEPS].xb[Q_W-1]}}, bx_r[SQRT_STEPS].xb});
    end
  end

  for (genvar w = 0; w < 2; w++) begin : g_vec
    for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_first
        hbd_vec_cell #(.STEP(i)) u_cell (
          .clk(clk), .en(adv), .a(vec_init_r[w]), .q_r(vec_q[w][i]));
      end else begin : g_next
        hbd_vec_cell #(.STEP(i)) u_cell (
          .clk(clk), .en(adv), .a(vec_q[w][i-1]), .q_r(vec_q[w][i]));
      end
    end
  end

  // E1: clamp the half angle, scale the bearing to degrees, wrap the heading.
  logic [31:0] ph_h, ph_b;
  logic [40:0] bprod;
  logic [24:0] braw;
  side_t sd_end;
  e1_t e1_nxt, e1_r;

  always_comb begin
    sd_end = sd_r[SD_LEN-1];
    ph_h = vec_q[0][N-1].zero ? 32'd0 : vec_q[0][N-1].z[31:0];
    ph_b = vec_q[1][N-1].zero ? 32'd0 : vec_q[1][N-1].z[31:0];
    if (ph_h[31]) begin
      e1_nxt.h = '0;
    end else if (ph_h[30:0] > 31'(ONE_Q30)) begin
      e1_nxt.h = 31'(ONE_Q30);
    end else begin
      e1_nxt.h = ph_h[30:0];
    end
    bprod = 41'(ph_b) * 41'd360 + 41'd32768;
    braw  = bprod[40:16];
    e1_nxt.bearing = (braw >= FULL_CIRCLE) ? (braw - FULL_CIRCLE) : braw;
    e1_nxt.head = (sd_end.head >= FULL_CIRCLE) ? (sd_end.head - FULL_CIRCLE)
                                               : sd_end.head;
    e1_nxt.present = sd_end.present;
  end

  // E2: distance products and the raw heading difference.
  e2_t e2_r;
  // E3: rounded distances and the wrapped difference.
  e3_t e3_r;
  logic [63:0] mi_sum, km_sum;
  // E4: result register.
  out_t out_r, out_nxt;

  always_comb begin
    mi_sum = e2_r.pm + 64'h80_0000_0000;
    km_sum = e2_r.pk + 64'h80_0000_0000;
  end

  // Verdict against the thresholds, tight test first.
  always_comb begin
    out_nxt.bearing = e3_r.bearing;
    out_nxt.mi      = e3_r.mi;
    out_nxt.km      = e3_r.km;
    out_nxt.vvalid  = e3_r.present;
    out_nxt.herr    = e3_r.present ? e3_r.diff : '0;
    if (!e3_r.present) begin
      out_nxt.verdict = VERDICT_TIGHT;
    end else begin
      priority if (e3_r.diff <= tight_r) begin
        out_nxt.verdict = VERDICT_TIGHT;
      end else if (e3_r.diff <= loose_r) begin
        out_nxt.verdict = VERDICT_LOOSE;
      end else begin
        out_nxt.verdict = VERDICT_BEYOND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r <= e1_nxt;

      e2_r.pm      <= 64'(e1_r.h) * 64'(MILE_MUL);
      e2_r.pk      <= 64'(e1_r.h) * 64'(KM_MUL);
      e2_r.bearing <= e1_r.bearing;
      e2_r.diff    <= (e1_r.bearing >= e1_r.head) ? (e1_r.bearing - e1_r.head)
                                                  : (e1_r.head - e1_r.bearing);
      e2_r.present <= e1_r.present;

      e3_r.mi      <= mi_sum[61:40];
      e3_r.km      <= km_sum[62:40];
      e3_r.bearing <= e2_r.bearing;
      e3_r.diff    <= (e2_r.diff > 25'(HALF_CIRCLE)) ? 24'(FULL_CIRCLE - e2_r.diff)
                                                     : e2_r.diff[23:0];
      e3_r.present <= e2_r.present;

      out_r <= out_nxt;
    end
  end

  // Result channel.
  assign out_ch.valid          = vld_r[L-1];
  assign out_ch.true_bearing   = out_r.bearing;
  assign out_ch.distance_miles = out_r.mi;
  assign out_ch.distance_km    = out_r.km;
  assign out_ch.heading_error  = out_r.herr;
  assign out_ch.verdict        = out_r.verdict;
  assign out_ch.verdict_valid  = out_r.vvalid;

  // Checks on the result register.
  `HBD_IMPLY(a_bearing_range, clk, rst_n, vld_r[L-1], out_r.bearing < FULL_CIRCLE)
  `HBD_IMPLY(a_no_heading_zero, clk, rst_n, vld_r[L-1] && !out_r.vvalid, (out_r.herr == '0) && (out_r.verdict == VERDICT_TIGHT))
  `HBD_IMPLY(a_error_range, clk, rst_n, vld_r[L-1] && out_r.vvalid, out_r.herr <= HALF_CIRCLE)
  `HBD_IMPLY(a_km_not_below_miles, clk, rst_n, vld_r[L-1], out_r.km >= {1'b0, out_r.mi})
  `HBD_ASSERT(a_verdict_code, clk, rst_n, !vld_r[L-1] || (out_r.verdict != 2'd3))

endmodule

// ----- verif/haversine_bearing_distance_top_tb.sv -----
// Self-checking testbench for haversine_bearing_distance_top: predicts bearing,
// distance and heading verdict for every input beat and checks the result stream.
// Depends on hbd_pkg, hbd_stream_if and the design files under design/.
`timescale 1ns / 1ps

module haversine_bearing_distance_top_tb;
  import hbd_pkg::*;

  localparam int ITERS = 24;
  localparam int SETTLE_CYCLES = 2 * ITERS + 43 + 20;
  localparam int STALL_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;
  localparam longint TURN = 23592960;

  typedef struct {
    logic signed [27:0] lat_from;
    logic signed [28:0] lon_from;
    logic signed [27:0] lat_to;
    logic signed [28:0] lon_to;
    logic [24:0]        heading;
    logic               present;
  } route_t;

  typedef struct {
    logic [24:0] bearing;
    logic [21:0] miles;
    logic [22:0] km;
    logic [23:0] herr;
    logic [1:0]  verdict;
    logic        vvalid;
  } fix_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hbd_in_if in_ch();
  hbd_out_if out_ch();

  haversine_bearing_distance_top #(.CORDIC_ITERATIONS(ITERS)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Testbench copy of the thresholds and the arctangent table.
  logic [23:0] tight_lim;
  logic [23:0] loose_lim;
  longint atan_rom [0:39] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  route_t route_q[$];
  fix_t   fix_q[$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int beats_in;
  int beats_out;
  int quiet_cycles;

  // Degrees (2^-20) to phase (2^-32 turn), floor division.
  function automatic logic [31:0] to_phase(input longint d);
    longint t;
    longint q;
    t = d * 4096 + 180;
    q = (t >= 0) ? t / 360 : -((-t + 359) / 360);
    return q[31:0];
  endfunction

  function automatic void rotate(input logic [31:0] ph, output longint s, output longint c);
    logic [31:0] z;
    bit flip;
    longint x, y, zs, xn, yn;
    z = ph;
    flip = 0;
    x = 652032874;
    y = 0;
    if (((z + 32'h40000000) & 32'h80000000) != 0) begin
      z = z + 32'h80000000;
      flip = 1;
    end
    zs = longint'(signed'(z));
    for (int i = 0; i < ITERS; i++) begin
      if (zs >= 0) begin
        xn = x - (y >>> i); yn = y + (x >>> i); zs -= atan_rom[i];
      end else begin
        xn = x + (y >>> i); yn = y - (x >>> i); zs += atan_rom[i];
      end
      x = xn; y = yn;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic logic [31:0] vector_angle(input longint yi, input longint xi);
    longint x, y, z, xn, yn;
    logic [31:0] base;
    x = xi; y = yi; z = 0; base = 0;
    if (x == 0 && y == 0) return 32'd0;
    if (x < 0) begin
      x = -x; y = -y; base = 32'h80000000;
    end
    for (int i = 0; i < ITERS; i++) begin
      if (y > 0) begin
        xn = x + (y >>> i); yn = y - (x >>> i); z += atan_rom[i];
      end else begin
        xn = x - (y >>> i); yn = y + (x >>> i); z -= atan_rom[i];
      end
      x = xn; y = yn;
    end
    return base + z[31:0];
  endfunction

  function automatic longint floor_root(input logic [63:0] n);
    logic [63:0] r, b, v;
    v = n; r = 0; b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b); r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  // Full prediction of one result beat.
  function automatic fix_t navigate(input route_t r);
    fix_t f;
    longint la1, lo1, la2, lo2;
    longint s1, c1, s2, c2, sdp, cdp, sdl, cdl, a, h, yb, xb, sa, sb, brg, hd, diff;
    la1 = r.lat_from; lo1 = r.lon_from; la2 = r.lat_to; lo2 = r.lon_to;
    rotate(to_phase(la1), s1, c1);
    rotate(to_phase(la2), s2, c2);
    rotate(to_phase(la2 - la1), sdp, cdp);
    rotate(to_phase(lo2 - lo1), sdl, cdl);
    a = ((1073741824 - cdp) >>> 1) + qmul(qmul(c1, c2), (1073741824 - cdl) >>> 1);
    if (a < 0) a = 0;
    if (a > 1073741824) a = 1073741824;
    sa = floor_root(64'(a) << 30);
    sb = floor_root(64'(1073741824 - a) << 30);
    h = longint'(signed'(vector_angle(sa, sb)));
    if (h < 0) h = 0;
    if (h > 1073741824) h = 1073741824;
    yb = qmul(sdl, c2);
    xb = qmul(c1, s2) - qmul(qmul(s1, c2), cdl);
    brg = (longint'({32'b0, vector_angle(yb, xb)}) * 360 + 32768) >> 16;
    if (brg >= TURN) brg -= TURN;
    f.bearing = brg[24:0];
    f.miles = 22'((h * 64'd3260268412 + (64'd1 << 39)) >> 40);
    f.km = 23'((h * 64'd5246880366 + (64'd1 << 39)) >> 40);
    f.herr = '0;
    f.verdict = VERDICT_TIGHT;
    f.vvalid = r.present;
    if (r.present) begin
      hd = longint'(r.heading);
      if (hd >= TURN) hd -= TURN;
      diff = (brg >= hd) ? brg - hd : hd - brg;
      if (diff > TURN / 2) diff = TURN - diff;
      f.herr = diff[23:0];
      if (diff <= longint'(tight_lim)) f.verdict = VERDICT_TIGHT;
      else if (diff <= longint'(loose_lim)) f.verdict = VERDICT_LOOSE;
      else f.verdict = VERDICT_BEYOND;
    end
    return f;
  endfunction

  function automatic longint pick_lat();
    if ($urandom_range(0, 99) < 8) return longint'(signed'(28'($urandom)));
    if ($urandom_range(0, 99) < 5) return ($urandom_range(0, 1)) ? 94371840 : -94371840;
    return longint'($urandom_range(0, 188743680)) - 94371840;
  endfunction

  function automatic longint pick_lon();
    if ($urandom_range(0, 99) < 8) return longint'(signed'(29'($urandom)));
    return longint'($urandom_range(0, 377487360)) - 188743680;
  endfunction

  // Random route; headings are often aimed at the threshold edges.
  function automatic route_t random_route();
    route_t r;
    fix_t f;
    longint off;
    r.lat_from = 28'(pick_lat());
    r.lon_from = 29'(pick_lon());
    if ($urandom_range(0, 99) < 30) begin
      r.lat_to = r.lat_from + 28'(longint'($urandom_range(0, 4000000)) - 2000000);
      r.lon_to = r.lon_from + 29'(longint'($urandom_range(0, 4000000)) - 2000000);
    end else begin
      r.lat_to = 28'(pick_lat());
      r.lon_to = 29'(pick_lon());
    end
    r.present = ($urandom_range(0, 99) < 75);
    r.heading = 25'($urandom_range(0, 23592959));
    if ($urandom_range(0, 99) < 10) r.heading = 25'($urandom);
    if ($urandom_range(0, 99) < 40) begin
      r.present = 1;
      f = navigate(r);
      case ($urandom_range(0, 5))
        0: off = tight_lim;
        1: off = longint'(tight_lim) + 1;
        2: off = loose_lim;
        3: off = longint'(loose_lim) + 1;
        4: off = 11796480;
        default: off = $urandom_range(0, 2000000);
      endcase
      if ($urandom_range(0, 1)) off = -off;
      off = (longint'(f.bearing) + off) % TURN;
      if (off < 0) off += TURN;
      r.heading = 25'(off);
    end
    return r;
  endfunction

  function automatic route_t mk(input longint a, input longint b, input longint c,
                                input longint d, input longint hd, input bit p);
    route_t r;
    r.lat_from = 28'(a); r.lon_from = 29'(b); r.lat_to = 28'(c); r.lon_to = 29'(d);
    r.heading = 25'(hd); r.present = p;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= 24'(val);
    if (idx == CFG_TIGHT) tight_lim = 24'(val);
    else if (idx == CFG_LOOSE) loose_lim = 24'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued beat has been sent and every result has come back.
  task automatic drain();
    do @(posedge clk);
    while (route_q.size() != 0 || fix_q.size() != 0 || in_ch.valid);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sender: presents queued routes, predicts on every accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        fix_q.push_back(navigate('{in_ch.lat_from, in_ch.lon_from, in_ch.lat_to,
                                   in_ch.lon_to, in_ch.measured_heading,
                                   in_ch.heading_present}));
        beats_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (route_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          route_t r;
          r = route_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.lat_from <= r.lat_from;
          in_ch.lon_from <= r.lon_from;
          in_ch.lat_to <= r.lat_to;
          in_ch.lon_to <= r.lon_to;
          in_ch.measured_heading <= r.heading;
          in_ch.heading_present <= r.present;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure and field-by-field comparison.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        beats_out++;
        if (fix_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Result beat with nothing expected");
        end else begin
          fix_t e;
          e = fix_q.pop_front();
          if (out_ch.true_bearing !== e.bearing || out_ch.distance_miles !== e.miles ||
              out_ch.distance_km !== e.km || out_ch.heading_error !== e.herr ||
              out_ch.verdict !== e.verdict || out_ch.verdict_valid !== e.vvalid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch beat %0d: exp brg %0d mi %0d km %0d err %0d v %0d vv %0d, got brg %0d mi %0d km %0d err %0d v %0d vv %0d",
                       beats_out, e.bearing, e.miles, e.km, e.herr, e.verdict, e.vvalid,
                       out_ch.true_bearing, out_ch.distance_miles, out_ch.distance_km,
                       out_ch.heading_error, out_ch.verdict, out_ch.verdict_valid);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat accepted on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("haversine_bearing_distance_top_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    longint tset [0:5] = '{327680, 0, 11796480, 5898240, 24'hFFFFFF, 65536};
    longint lset [0:5] = '{983040, 0, 11796480, 65536, 0, 2000000};
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.lat_from = '0; in_ch.lon_from = '0; in_ch.lat_to = '0;
    in_ch.lon_to = '0; in_ch.measured_heading = '0; in_ch.heading_present = 1'b0;
    out_ch.ready = 1'b0;
    tight_lim = TIGHT_RESET;
    loose_lim = LOOSE_RESET;
    send_idle_pct = 9; recv_idle_pct = 57;
    mismatches = 0; beats_in = 0; beats_out = 0; quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: same point, poles, antimeridian, range edges, heading cases.
    route_q.push_back(mk(0, 0, 0, 0, 0, 1));
    route_q.push_back(mk(94371840, 0, 94371840, 5000, 100, 1));
    route_q.push_back(mk(-94371840, 0, 94371840, 0, 0, 1));
    route_q.push_back(mk(94371840, 188743680, -94371840, -188743680, 23592959, 1));
    route_q.push_back(mk(0, 188743680, 0, -188743680, 23592960, 1));
    route_q.push_back(mk(0, -188743680, 0, 188743680, 25'h1FFFFFF, 1));
    route_q.push_back(mk(0, 0, 0, 188743680, 5898240, 1));
    route_q.push_back(mk(0, 0, 0, -188743680, 0, 0));
    route_q.push_back(mk(-94371840, -188743680, -94371840, 188743680, 1, 1));
    route_q.push_back(mk(-134217728, -268435456, 134217727, 268435455, 11796480, 1));
    route_q.push_back(mk(134217727, 268435455, -134217728, -268435456, 0, 1));
    route_q.push_back(mk(42000000, -77000000, 42000001, -77000000, 0, 1));
    route_q.push_back(mk(42000000, -77000000, 42000000, -77000001, 17694720, 1));
    route_q.push_back(mk(10000000, 20000000, -30000000, 150000000, 25'h1FFFFFF, 0));
    route_q.push_back(mk(0, 0, 1, 0, 327680, 1));
    route_q.push_back(mk(0, 0, 0, 1, 983040, 1));
    route_q.push_back(mk(0, 0, 0, 1, 983041, 1));
    route_q.push_back(mk(0, 0, 0, 1, 5898241, 1));
    drain();

    // Random phases with different thresholds and idling patterns.
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_TIGHT, tset[p]);
      write_reg(CFG_LOOSE, lset[p]);
      if (p == 3) write_reg(CFG_UNUSED, 24'h123456);
      send_idle_pct = (p < 2) ? 9 : (p < 4) ? 57 : 0;
      recv_idle_pct = (p < 2) ? 57 : (p < 4) ? 9 : 0;
      for (int k = 0; k < 215; k++) route_q.push_back(random_route());
      drain();
    end

    $display("Covered %0d input beats and %0d result beats over six threshold settings",
             beats_in, beats_out);
    $display("and three idling patterns; %0d mismatches.", mismatches);
    if (mismatches == 0 && fix_q.size() == 0) begin
      $display("haversine_bearing_distance_top_tb: PASS");
    end else begin
      $display("haversine_bearing_distance_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/hbd_pkg.sv
design/hbd_stream_if.sv
design/hbd_phase_cell.sv
design/hbd_rot_cell.sv
design/hbd_sqrt_cell.sv
design/hbd_vec_cell.sv
design/haversine_bearing_distance_top.sv
verif/haversine_bearing_distance_top_tb.sv
